// ----- sv/rqas_pkg.sv -----
// Package for the ready queue actor scheduler.
// Holds the command codes, configuration register indexes, field widths
// and the controller state type. Depends on nothing.
`default_nettype none
package rqas_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int SEND_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ACNT_W  = 7;
  localparam int CCNT_W  = 4;

  localparam logic [CMD_W-1:0] CMD_GET_NEXT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCAL_READY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOTE_READY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTOR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_DRAIN_WR,
    S_POP,
    S_POP_WR
  } state_t;

endpackage
`default_nettype wire

// ----- sv/rqas_ring_mem.sv -----
// Simple dual-port synchronous memory used for the ready and waiting rings.
// One write port, one read port with registered read data. No package use.
`default_nettype none
module rqas_ring_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/ready_queue_actor_scheduler_core.sv -----
// Ready queue actor scheduler top level; uses rqas_pkg and two rqas_ring_mem rings.
// Ready commands never raise busy; round-robin get next shows its result in the
// cycle after the transfer. Otherwise get next walks S_DRAIN and S_DRAIN_WR over
// each core's waiting ring, moving every waiting entry to the ready ring, then S_POP
// (and S_POP_WR when the ready ring is popped); busy drops as the result shows.
// Reset is synchronous; marks and pointers clear at once, no clearing pass.
`default_nettype none
module ready_queue_actor_scheduler_core
  import rqas_pkg::*;
#(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_CORES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [SLOT_W-1:0]     actor_slot,
  input  wire logic [SEND_W-1:0]     sender,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic                       done,
  output logic                       found,
  output logic [SLOT_W-1:0]          chosen_slot,
  output logic                       by_round_robin
);

  localparam int SW   = $clog2(MAX_SLOTS);
  localparam int NW   = SW + 1;
  localparam int RD   = 2 * MAX_SLOTS;
  localparam int RIW  = $clog2(RD);
  localparam int PW   = $clog2(4 * MAX_SLOTS);
  localparam int WPW  = $clog2(2 * MAX_SLOTS);
  localparam int WAW  = $clog2(MAX_CORES * MAX_SLOTS);
  localparam int CIW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CCW  = $clog2(MAX_CORES + 1);

  state_t state, state_next;

  logic              mode;
  logic [ACNT_W-1:0] actor_count;
  logic [CCNT_W-1:0] core_count;

  logic [MAX_SLOTS-1:0] ready_mark;
  logic [MAX_SLOTS-1:0] waiting_mark;
  logic [PW-1:0]        ready_head;
  logic [PW-1:0]        ready_tail;
  logic [WPW-1:0]       waiting_heads [MAX_CORES];
  logic [WPW-1:0]       waiting_tails [MAX_CORES];
  logic [SW-1:0]        rotate_pointer;
  logic [CCW-1:0]       core_idx;

  // Effective counts after clamping.
  logic [NW-1:0]  n_actors;
  logic [CCW-1:0] n_cores;

  always_comb begin
    if (32'(actor_count) > MAX_SLOTS) n_actors = NW'(MAX_SLOTS);
    else n_actors = NW'(actor_count);
    if (32'(core_count) > MAX_CORES) n_cores = CCW'(MAX_CORES);
    else n_cores = CCW'(core_count);
  end

  logic           slot_ok;
  logic [SW-1:0]  slot_i;
  logic           sender_ok;
  logic [CIW-1:0] sender_i;
  logic [CIW-1:0] c_i;
  logic [CIW-1:0] tail_sel;

  assign slot_ok   = 32'(actor_slot) < MAX_SLOTS;
  assign slot_i    = SW'(actor_slot);
  assign sender_ok = 32'(sender) < 32'(n_cores);
  assign sender_i  = CIW'(sender);
  assign c_i       = CIW'(core_idx);
  assign tail_sel  = (state == S_IDLE) ? sender_i : c_i;

  // Round-robin pick.
  logic [NW-1:0] rr_pos;
  logic [NW-1:0] rr_inc;
  logic [SW-1:0] rr_next;

  always_comb begin
    rr_pos = (NW'(rotate_pointer) >= n_actors) ? '0 : NW'(rotate_pointer);
    rr_inc = rr_pos + NW'(1);
    rr_next = (rr_inc >= n_actors) ? '0 : SW'(rr_inc);
  end

  // Ring index arithmetic.
  logic [RIW-1:0] rtail_idx, rhead_idx;
  logic [PW-1:0]  rtail_inc, rhead_inc;
  logic [WPW-1:0] whead_c, wtail_s;
  logic [SW-1:0]  whead_idx, wtail_idx;
  logic [WPW-1:0] whead_inc, wtail_inc;

  always_comb begin
    rtail_idx = (ready_tail >= PW'(RD)) ? RIW'(ready_tail - PW'(RD)) : RIW'(ready_tail);
    rhead_idx = (ready_head >= PW'(RD)) ? RIW'(ready_head - PW'(RD)) : RIW'(ready_head);
    rtail_inc = (ready_tail == PW'(4 * MAX_SLOTS - 1)) ? '0 : ready_tail + PW'(1);
    rhead_inc = (ready_head == PW'(4 * MAX_SLOTS - 1)) ? '0 : ready_head + PW'(1);
    whead_c   = waiting_heads[c_i];
    wtail_s   = waiting_tails[tail_sel];
    whead_idx = (whead_c >= WPW'(MAX_SLOTS)) ? SW'(whead_c - WPW'(MAX_SLOTS)) : SW'(whead_c);
    wtail_idx = (wtail_s >= WPW'(MAX_SLOTS)) ? SW'(wtail_s - WPW'(MAX_SLOTS)) : SW'(wtail_s);
    whead_inc = (whead_c == WPW'(2 * MAX_SLOTS - 1)) ? '0 : whead_c + WPW'(1);
    wtail_inc = (wtail_s == WPW'(2 * MAX_SLOTS - 1)) ? '0 : wtail_s + WPW'(1);
  end

  // Memory ports.
  logic           r_we;
  logic [RIW-1:0] r_waddr;
  logic [SW-1:0]  r_wdata;
  logic [SW-1:0]  r_rdata;
  logic           w_we;
  logic [WAW-1:0] w_waddr;
  logic [WAW-1:0] w_raddr;
  logic [SW-1:0]  w_rdata;

  assign w_waddr = WAW'(32'(sender_i) * MAX_SLOTS) + WAW'(wtail_idx);
  assign w_raddr = WAW'(32'(c_i) * MAX_SLOTS) + WAW'(whead_idx);
  assign r_waddr = rtail_idx;

  rqas_ring_mem #(.DEPTH(RD), .WIDTH(SW)) u_ready_mem (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (rhead_idx),
    .rdata (r_rdata)
  );

  rqas_ring_mem #(.DEPTH(MAX_CORES * MAX_SLOTS), .WIDTH(SW)) u_wait_mem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (slot_i),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  logic accept;
  logic do_local, do_remote, do_rr, do_pop;
  logic drain_pending;

  assign accept        = start && (state == S_IDLE);
  assign busy          = (state != S_IDLE);
  assign drain_pending = (whead_c != waiting_tails[c_i]);

  always_comb begin
    state_next = state;
    do_local   = 1'b0;
    do_remote  = 1'b0;
    do_rr      = 1'b0;
    do_pop     = 1'b0;
    r_we       = 1'b0;
    r_wdata    = slot_i;
    w_we       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_GET_NEXT: begin
              if (!mode) do_rr = 1'b1;
              else state_next = S_DRAIN;
            end
            CMD_LOCAL_READY: begin
              do_local = slot_ok && !ready_mark[slot_i];
              r_we     = do_local;
            end
            CMD_REMOTE_READY: begin
              do_remote = slot_ok && sender_ok && !ready_mark[slot_i] && !waiting_mark[slot_i];
              w_we      = do_remote;
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (core_idx >= n_cores) state_next = S_POP;
        else if (drain_pending) state_next = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        r_we       = 1'b1;
        r_wdata    = w_rdata;
        state_next = S_DRAIN;
      end
      S_POP: begin
        if (ready_head == ready_tail) begin
          do_rr      = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_POP_WR;
        end
      end
      S_POP_WR: begin
        do_pop     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b1;
      actor_count <= '0;
      core_count  <= CCNT_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:        mode        <= wr_data[0];
        REG_ACTOR_COUNT: actor_count <= ACNT_W'(wr_data);
        REG_CORE_COUNT:  core_count  <= CCNT_W'(wr_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mark     <= '0;
      waiting_mark   <= '0;
      ready_head     <= '0;
      ready_tail     <= '0;
      rotate_pointer <= '0;
      core_idx       <= '0;
      done           <= 1'b0;
      for (int i = 0; i < MAX_CORES; i++) begin
        waiting_heads[i] <= '0;
        waiting_tails[i] <= '0;
      end
    end else begin
      done <= do_rr || do_pop;
      if (accept) core_idx <= '0;
      if (do_local) begin
        ready_mark[slot_i] <= 1'b1;
        ready_tail         <= rtail_inc;
      end
      if (do_remote) begin
        waiting_mark[slot_i]    <= 1'b1;
        waiting_tails[tail_sel] <= wtail_inc;
      end
      if (state == S_DRAIN && core_idx < n_cores && !drain_pending) begin
        core_idx <= core_idx + CCW'(1);
      end
      if (state == S_DRAIN_WR) begin
        // The drained entry moves to the ready ring even if already marked.
        ready_mark[w_rdata]   <= 1'b1;
        waiting_mark[w_rdata] <= 1'b0;
        ready_tail            <= rtail_inc;
        waiting_heads[c_i]    <= whead_inc;
      end
      if (do_pop) begin
        ready_mark[r_rdata] <= 1'b0;
        ready_head          <= rhead_inc;
      end
      if (do_rr && n_actors != '0) rotate_pointer <= rr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rr) begin
      found          <= (n_actors != '0);
      chosen_slot    <= (n_actors != '0) ? SLOT_W'(rr_pos) : '0;
      by_round_robin <= 1'b1;
    end else if (do_pop) begin
      found          <= 1'b1;
      chosen_slot    <= SLOT_W'(r_rdata);
      by_round_robin <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rqas_checker.sv -----
// Port-level checker for the ready queue actor scheduler, with its bind.
// Uses rqas_pkg for the command codes.
`default_nettype none
module rqas_checker
  import rqas_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [CMD_W-1:0]  command,
  input wire logic              done,
  input wire logic              found,
  input wire logic [SLOT_W-1:0] chosen_slot,
  input wire logic              by_round_robin
);

  // A result always leaves the block ready for the next command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // Without an actor the result is the empty round-robin answer.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
      (done && !found) |-> (by_round_robin && chosen_slot == '0))
    else $error("empty result carries a slot");

  // Only a get next transfer can start a busy period.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
      $rose(busy) |-> $past(start && command == CMD_GET_NEXT))
    else $error("busy without get next");

  // A result follows either a busy period or a get next transfer.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
      done |-> ($past(busy) || $past(start && command == CMD_GET_NEXT)))
    else $error("result without get next");

endmodule

bind ready_queue_actor_scheduler_core rqas_checker u_rqas_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .command        (command),
  .done           (done),
  .found          (found),
  .chosen_slot    (chosen_slot),
  .by_round_robin (by_round_robin)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for ready_queue_actor_scheduler_core.
// Drives commands from a directed table and then at random, and checks each
// result against a scheduling predictor. Depends on rqas_pkg and the core.
`timescale 1ns / 1ps
module tb_top;
  import rqas_pkg::*;

  localparam int SLOTS = 64;
  localparam int CORES = 8;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic                rr;
  } pick_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [SEND_W-1:0] snd;
    bit                typed;
    pick_t             want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [CMD_W-1:0] command = '0;
  logic [SLOT_W-1:0] actor_slot = '0;
  logic [SEND_W-1:0] sender = '0;
  logic wr_en = 0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic busy, done, found, by_round_robin;
  logic [SLOT_W-1:0] chosen_slot;

  ready_queue_actor_scheduler_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Scheduler shadow state.
  bit          sh_mode;
  int unsigned sh_actors, sh_cores;
  bit          rdy_mark[SLOTS], wait_mark[SLOTS];
  int unsigned ready_q[$];
  int unsigned wait_q[CORES][$];
  int unsigned rotor;

  pick_t picks_due[$];
  int errors = 0;
  int mismatches = 0;

  function automatic pick_t rotate_pick();
    pick_t p;
    int unsigned n;
    n = sh_actors > SLOTS ? SLOTS : sh_actors;
    p.rr = 1;
    if (n == 0) begin
      p.found = 0;
      p.slot = '0;
      return p;
    end
    if (rotor >= n) rotor = 0;
    p.found = 1;
    p.slot = rotor[SLOT_W-1:0];
    rotor++;
    if (rotor >= n) rotor = 0;
    return p;
  endfunction

  // Returns 1 and fills p when the command yields a pick.
  function automatic bit schedule(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                                  logic [SEND_W-1:0] snd, output pick_t p);
    int unsigned nc, v;
    nc = sh_cores > CORES ? CORES : sh_cores;
    p = '0;
    if (c == CMD_GET_NEXT) begin
      if (sh_mode == 0) begin
        p = rotate_pick();
        return 1;
      end
      for (int k = 0; k < nc; k++) begin
        while (wait_q[k].size() > 0) begin
          v = wait_q[k].pop_front();
          ready_q.push_back(v);
          rdy_mark[v] = 1;
          wait_mark[v] = 0;
        end
      end
      if (ready_q.size() == 0) p = rotate_pick();
      else begin
        v = ready_q.pop_front();
        rdy_mark[v] = 0;
        p.found = 1;
        p.slot = v[SLOT_W-1:0];
        p.rr = 0;
      end
      return 1;
    end
    if (c == CMD_LOCAL_READY) begin
      if (!rdy_mark[s]) begin
        ready_q.push_back(s);
        rdy_mark[s] = 1;
      end
    end else if (c == CMD_REMOTE_READY) begin
      if (snd < nc && !rdy_mark[s] && !wait_mark[s]) begin
        wait_q[snd].push_back(s);
        wait_mark[s] = 1;
      end
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    pick_t e;
    if (!rst && done) begin
      if (picks_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result slot %0d", chosen_slot);
      end else begin
        e = picks_due.pop_front();
        if (found !== e.found || chosen_slot !== e.slot || by_round_robin !== e.rr) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected found %0b slot %0d rr %0b, got %0b %0d %0b",
                     e.found, e.slot, e.rr, found, chosen_slot, by_round_robin);
        end
      end
    end
  end

  // The write enable is dropped again after the write and is low when the task returns, so writes never abut.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    wr_en <= 0;
    @(posedge clk);
    if (idx == REG_MODE) sh_mode = val[0];
    else if (idx == REG_ACTOR_COUNT) sh_actors = val & 127;
    else if (idx == REG_CORE_COUNT) sh_cores = val & 15;
  endtask

  // Waits for all outstanding results, then lets the block settle.
  task automatic settle();
    start <= 0;
    while (picks_due.size() > 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Presents one command and holds it until the transfer takes place.
  // Start stays high after the transfer until the next command or an idle cycle.
  task automatic issue(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                       logic [SEND_W-1:0] snd, bit typed, pick_t want, bit gaps);
    pick_t p;
    if (gaps) while ($urandom_range(99) < 33) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= c;
    actor_slot <= s;
    sender <= snd;
    do @(posedge clk); while (busy);
    if (schedule(c, s, snd, p)) begin
      if (typed && p != want) begin
        errors++;
        $display("predictor disagrees with table row for slot %0d", want.slot);
      end
      picks_due.push_back(p);
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(logic [CMD_W-1:0] c, int s, int snd, bit t,
                              bit f, int cs, bit r);
    row_t x;
    x.cmd = c; x.slot = SLOT_W'(s); x.snd = SEND_W'(snd); x.typed = t;
    x.want.found = f; x.want.slot = SLOT_W'(cs); x.want.rr = r;
    return x;
  endfunction

  initial begin
    pick_t none;
    logic [CMD_W-1:0] c;
    int unsigned r, burst;
    none = '0;
    sh_mode = 1; sh_actors = 0; sh_cores = 1; rotor = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // After reset: no actors, empty ring.
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 1, 0, 0, 1));
    rows.push_back(mk(CMD_LOCAL_READY, 63, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_LOCAL_READY, 63, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_LOCAL_READY, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_REMOTE_READY, 5, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_REMOTE_READY, 6, 7, 0, 0, 0, 0));
    rows.push_back(mk(2'd3, 7, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 1, 1, 63, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 1, 1, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 1, 1, 5, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 1, 0, 0, 1));
    foreach (rows[i]) issue(rows[i].cmd, rows[i].slot, rows[i].snd,
                            rows[i].typed, rows[i].want, 0);
    settle();

    // Extremes: all cores, too many actors, waiting actor made local ready.
    write_reg(REG_CORE_COUNT, 15);
    write_reg(REG_ACTOR_COUNT, 127);
    rows.delete();
    rows.push_back(mk(CMD_REMOTE_READY, 9, 7, 0, 0, 0, 0));
    rows.push_back(mk(CMD_REMOTE_READY, 9, 3, 0, 0, 0, 0));
    rows.push_back(mk(CMD_LOCAL_READY, 9, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_REMOTE_READY, 10, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(CMD_GET_NEXT, 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) issue(rows[i].cmd, rows[i].slot, rows[i].snd, 0, none, 0);
    settle();
    write_reg(REG_MODE, 0);
    write_reg(REG_ACTOR_COUNT, 3);
    issue(CMD_LOCAL_READY, SLOT_W'(1), SEND_W'(0), 0, none, 0);
    for (int i = 0; i < 4; i++) issue(CMD_GET_NEXT, SLOT_W'(0), SEND_W'(0), 0, none, 0);
    settle();
    write_reg(REG_CORE_COUNT, 0);
    write_reg(REG_MODE, 1);
    issue(CMD_REMOTE_READY, SLOT_W'(2), SEND_W'(0), 0, none, 0);
    issue(CMD_GET_NEXT, SLOT_W'(0), SEND_W'(0), 0, none, 0);
    settle();

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_MODE, (ph % 5 == 4) ? 0 : 1);
      write_reg(REG_ACTOR_COUNT, ph == 0 ? 0 : ph == 1 ? 64 : ph == 2 ? 1 :
                $urandom_range(127));
      write_reg(REG_CORE_COUNT, ph == 3 ? 8 : $urandom_range(15));
      for (int i = 0; i < 140; i++) begin
        r = $urandom_range(99);
        if (r < 30) c = CMD_GET_NEXT;
        else if (r < 60) c = CMD_LOCAL_READY;
        else if (r < 97) c = CMD_REMOTE_READY;
        else c = 2'd3;
        // Phase 6 runs without any idle gaps.
        issue(c, SLOT_W'($urandom_range(63)), SEND_W'($urandom_range(7)), 0, none,
              ph != 6);
        if (i == 70 && ph == 5) settle();
      end
      settle();
    end

    while (picks_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/rqas_pkg.sv
sv/rqas_ring_mem.sv
sv/ready_queue_actor_scheduler_core.sv
sv/rqas_checker.sv
verif/tb_top.sv
